@@ hw/rtl/voltage_window_classifier_debounced_assert.svh @@
// Assertion macros for the voltage window classifier.
// Both forms vanish when SYNTHESIS is defined.
`ifndef VOLTAGE_WINDOW_CLASSIFIER_DEBOUNCED_ASSERT_SVH
`define VOLTAGE_WINDOW_CLASSIFIER_DEBOUNCED_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at each rising edge, suspended while reset is asserted.
`define VWCD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("vwcd assertion failed");

// Property checked at each rising edge, reset included.
`define VWCD_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("vwcd assertion failed");

`else

`define VWCD_ASSERT(label, clk, rst_n, prop)
`define VWCD_ASSERT_NR(label, clk, prop)

`endif

`endif

@@ hw/rtl/vwc_pkg.sv @@
package vwc_pkg;

	// field widths
	localparam int THR_BITS        = 12;
	localparam int CNT_BITS        = 16;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CODE_BITS       = 3;

	typedef logic [CODE_BITS-1:0] level_t;
	typedef logic [CODE_BITS-1:0] zone_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// confirmed level codes
	localparam level_t LV_NORMAL = 3'd0;
	localparam level_t LV_STOP   = 3'd1;
	localparam level_t LV_LOW    = 3'd2;
	localparam level_t LV_HIGH   = 3'd3;
	localparam level_t LV_OVER   = 3'd4;
	// marks a band zone, which never matches a confirmed level
	localparam level_t LV_NONE   = 3'd7;

	// raw zone codes
	localparam zone_t Z_NORMAL = 3'd0;
	localparam zone_t Z_STOP   = 3'd1;
	localparam zone_t Z_LOW    = 3'd2;
	localparam zone_t Z_LBAND  = 3'd3;
	localparam zone_t Z_HBAND  = 3'd4;
	localparam zone_t Z_HIGH   = 3'd5;
	localparam zone_t Z_OVER   = 3'd6;

	// register indexes
	localparam cfg_idx_t REG_STOP_LEVEL    = 3'd0;
	localparam cfg_idx_t REG_LOW_LEVEL     = 3'd1;
	localparam cfg_idx_t REG_LOW_BAND      = 3'd2;
	localparam cfg_idx_t REG_HIGH_LEVEL    = 3'd3;
	localparam cfg_idx_t REG_HIGH_BAND     = 3'd4;
	localparam cfg_idx_t REG_OVER_LEVEL    = 3'd5;
	localparam cfg_idx_t REG_CONFIRM_COUNT = 3'd6;

	// register reset values
	localparam logic [THR_BITS-1:0] THR_ZERO = '0;
	localparam logic [THR_BITS-1:0] THR_FULL = '1;

	// window thresholds handed to the classifier
	typedef struct packed {
		logic [THR_BITS-1:0] stop_level;
		logic [THR_BITS-1:0] low_level;
		logic [THR_BITS-1:0] low_band;
		logic [THR_BITS-1:0] high_level;
		logic [THR_BITS-1:0] high_band;
		logic [THR_BITS-1:0] over_level;
	} thr_t;

	// level code that a raw zone stands for
	function automatic level_t zone_as_level(input zone_t z);
		level_t r;
		case (z)
			Z_NORMAL: r = LV_NORMAL;
			Z_STOP:   r = LV_STOP;
			Z_LOW:    r = LV_LOW;
			Z_HIGH:   r = LV_HIGH;
			Z_OVER:   r = LV_OVER;
			default:  r = LV_NONE;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/vwc_zone.sv @@
// Sorts one sample into its raw zone. Band edges are computed exactly,
// with two spare bits so the sum cannot wrap and the difference may go negative.
module vwc_zone #(
	parameter int SAMPLE_BITS = vwc_pkg::SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0] sample,
	input  vwc_pkg::thr_t          thr,
	output vwc_pkg::zone_t         zone
);
	import vwc_pkg::*;

	localparam int WIDE_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
	localparam int CW        = WIDE_BITS + 2;

	logic signed [CW-1:0] s_w;
	logic signed [CW-1:0] stop_w;
	logic signed [CW-1:0] low_w;
	logic signed [CW-1:0] high_w;
	logic signed [CW-1:0] over_w;
	logic signed [CW-1:0] hi_lim;
	logic signed [CW-1:0] lo_lim;

	// zero-extend everything into a common signed width
	assign s_w    = signed'({{(CW-SAMPLE_BITS){1'b0}}, sample});
	assign stop_w = signed'({{(CW-THR_BITS){1'b0}}, thr.stop_level});
	assign low_w  = signed'({{(CW-THR_BITS){1'b0}}, thr.low_level});
	assign high_w = signed'({{(CW-THR_BITS){1'b0}}, thr.high_level});
	assign over_w = signed'({{(CW-THR_BITS){1'b0}}, thr.over_level});
	assign hi_lim = high_w + signed'({{(CW-THR_BITS){1'b0}}, thr.high_band});
	assign lo_lim = low_w - signed'({{(CW-THR_BITS){1'b0}}, thr.low_band});

	// zone tests in priority order
	always_comb begin
		if (s_w >= low_w && s_w <= high_w) begin
			zone = Z_NORMAL;
		end else if (s_w > high_w) begin
			if (s_w < hi_lim) begin
				zone = Z_HBAND;
			end else if (s_w <= over_w) begin
				zone = Z_HIGH;
			end else begin
				zone = Z_OVER;
			end
		end else if (s_w > lo_lim) begin
			zone = Z_LBAND;
		end else if (s_w >= stop_w) begin
			zone = Z_LOW;
		end else begin
			zone = Z_STOP;
		end
	end

endmodule

@@ hw/rtl/voltage_window_classifier_debounced.sv @@
// Channel  | handshake                | payload
// ---------+--------------------------+------------------------------------
// in       | in_valid / in_stall      | sample [SAMPLE_BITS]
// out      | out_valid / out_stall    | level [3], raw_zone [3]
// cfg      | cfg_valid / cfg_ready    | cfg_index [3], cfg_data [16]
//
// One sample per cycle sustained while out_stall is low; from its beat a sample passes through
// the input register, then classify and debounce into the result register, to the outputs.
// The confirmed level and counter update as a sample moves into the result register.
// out_stall holds the result register and, once the input register is full, in_stall.
// Config is always ready. arst_n clears valids, state and config registers to defaults.
`include "voltage_window_classifier_debounced_assert.svh"

module voltage_window_classifier_debounced #(
	parameter int SAMPLE_BITS = vwc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output vwc_pkg::level_t                    level,
	output vwc_pkg::zone_t                     raw_zone,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  vwc_pkg::cfg_idx_t                  cfg_index,
	input  logic [vwc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import vwc_pkg::*;

	thr_t                  thr_q;
	logic [CNT_BITS-1:0]   confirm_count_q;
	level_t                lvl_q;
	logic [CNT_BITS-1:0]   cnt_q;

	logic                  valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                  valid_s2;
	level_t                level_s2;
	zone_t                 zone_s2;

	logic                  in_beat;
	logic                  s1_adv;
	zone_t                 zone_c;
	level_t                lvl_nxt;
	logic [CNT_BITS-1:0]   cnt_nxt;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.stop_level <= THR_ZERO;
			thr_q.low_level  <= THR_ZERO;
			thr_q.low_band   <= THR_ZERO;
			thr_q.high_level <= THR_FULL;
			thr_q.high_band  <= THR_ZERO;
			thr_q.over_level <= THR_FULL;
			confirm_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STOP_LEVEL:    thr_q.stop_level <= cfg_data[THR_BITS-1:0];
				REG_LOW_LEVEL:     thr_q.low_level  <= cfg_data[THR_BITS-1:0];
				REG_LOW_BAND:      thr_q.low_band   <= cfg_data[THR_BITS-1:0];
				REG_HIGH_LEVEL:    thr_q.high_level <= cfg_data[THR_BITS-1:0];
				REG_HIGH_BAND:     thr_q.high_band  <= cfg_data[THR_BITS-1:0];
				REG_OVER_LEVEL:    thr_q.over_level <= cfg_data[THR_BITS-1:0];
				REG_CONFIRM_COUNT: confirm_count_q  <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 drains whenever the result register is free or leaving
	assign s1_adv   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_beat  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_s1 <= sample;
		end
	end

	vwc_zone #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_zone (
		.sample (sample_s1),
		.thr    (thr_q),
		.zone   (zone_c)
	);

	// debounce: count differing samples, adopt once the count is reached
	always_comb begin
		lvl_nxt = lvl_q;
		cnt_nxt = '0;
		if (zone_as_level(zone_c) != lvl_q) begin
			if (cnt_q < confirm_count_q) begin
				cnt_nxt = cnt_q + 1'b1;
			end else if (zone_c == Z_LBAND) begin
				lvl_nxt = (lvl_q == LV_LOW || lvl_q == LV_STOP) ? LV_LOW : LV_NORMAL;
			end else if (zone_c == Z_HBAND) begin
				lvl_nxt = (lvl_q == LV_HIGH || lvl_q == LV_OVER) ? LV_HIGH : LV_NORMAL;
			end else begin
				lvl_nxt = zone_as_level(zone_c);
			end
		end
	end

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= LV_NORMAL;
			cnt_q <= '0;
		end else if (s1_adv) begin
			lvl_q <= lvl_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			level_s2 <= lvl_nxt;
			zone_s2  <= zone_c;
		end
	end

	assign out_valid = valid_s2;
	assign level     = level_s2;
	assign raw_zone  = zone_s2;

	// a held sample stays in the input register
	`VWCD_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv |=> valid_s1)
	// a level change always clears the counter
	`VWCD_ASSERT(a_adopt_clears, clk, arst_n, !$stable(lvl_q) |-> cnt_q == '0)
	// debounce state moves only with a sample entering the result register
	`VWCD_ASSERT(a_cnt_on_adv, clk, arst_n, !$stable(cnt_q) |-> $past(s1_adv))
	// a result is only dropped after its beat
	`VWCD_ASSERT(a_out_drop, clk, arst_n, $fell(valid_s2) |-> !$past(out_stall))

endmodule
